// ===== src/frpp_pkg.sv =====
// Package for the FEC redundancy pacing planner.
// Holds the shared types, register codes and pipeline constants; no dependencies.
`timescale 1ns / 1ps

package frpp_pkg;

  // Field widths of the configuration registers and the item fields.
  localparam int SymW   = 9;
  localparam int RatioW = 10;
  localparam int TailW  = 9;
  localparam int IdxW   = 8;
  localparam int PktW   = 9;
  localparam int TotW   = 12;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 10;

  // Remainder pipeline: dividend bits, bits per stage and stage count.
  localparam int DvdW      = 9;
  localparam int DsrW      = 10;
  localparam int RemSteps  = 3;
  localparam int RemStages = DvdW / RemSteps;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_SYMBOL_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SEND_RATIO   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TAIL_COUNT   = 2'd2;

  // Sequencer states of the per-configuration planning unit.
  typedef enum logic [3:0] {
    PL_BASE,
    PL_REM,
    PL_MUL,
    PL_EST,
    PL_RED,
    PL_TAIL,
    PL_DIV,
    PL_SPAN,
    PL_DONE
  } plan_state_e;

  // Values derived from the configuration, constant while items flow.
  typedef struct packed {
    logic             done;
    logic [SymW-1:0]  s;
    logic [3:0]       base;
    logic [TailW-1:0] tail;
    logic [SymW-1:0]  pace;
    logic [SymW-1:0]  q;
    logic [SymW-1:0]  big_span;
    logic [TotW-1:0]  total;
    logic             clamped;
  } plan_t;

  // Payload of one item inside the remainder pipeline.
  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [DvdW-1:0] dvd;
    logic [DsrW-1:0] dsr;
    logic [DsrW-1:0] rem;
  } rem_t;

endpackage

// ===== src/frpp_plan.sv =====
// Configuration registers and the sequencer that derives the pacing plan from them.
// Depends on frpp_pkg for the plan type, register codes and state enum.
`timescale 1ns / 1ps

module frpp_plan #(
  parameter int MAX_SYMBOLS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [frpp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [frpp_pkg::CfgDataW-1:0]  cfg_data_i,
  output frpp_pkg::plan_t                plan_o
);
  import frpp_pkg::*;

  localparam logic [12:0] MaxSym = 13'(MAX_SYMBOLS);

  logic [SymW-1:0]   symbol_count_q;
  logic [RatioW-1:0] send_ratio_q;
  logic [TailW-1:0]  tail_count_q;
  logic              cfg_we;

  plan_state_e state_q, state_d;

  logic [SymW-1:0]  s_q;
  logic [3:0]       base_q;
  logic [6:0]       pct_q;
  logic [15:0]      v_q;
  logic [12:0]      sbase_q;
  logic [SymW-1:0]  est_q;
  logic [SymW-1:0]  red_q;
  logic [TailW-1:0] tail_q;
  logic [SymW-1:0]  pace_q;
  logic [TotW-1:0]  total_q;
  logic             clamped_q;
  logic [DsrW-1:0]  div_rem_q;
  logic [SymW-1:0]  div_dvd_q;
  logic [SymW-1:0]  div_quo_q;
  logic [3:0]       div_cnt_q;
  logic [SymW-1:0]  q_q;
  logic [SymW-1:0]  big_span_q;

  logic [SymW-1:0]  s_eff;
  logic [15:0]      base_prod;
  logic [10:0]      pct_full;
  logic [25:0]      est_prod;
  logic [15:0]      red_rv;
  logic [13:0]      tot_sum;
  logic [DsrW:0]    div_shift;
  logic [DsrW:0]    div_sub;
  logic [18:0]      span_prod;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbol_count_q <= 9'd16;
      send_ratio_q   <= 10'd100;
      tail_count_q   <= 9'd0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_SYMBOL_COUNT: symbol_count_q <= cfg_data_i[SymW-1:0];
        CFG_SEND_RATIO:   send_ratio_q   <= cfg_data_i[RatioW-1:0];
        CFG_TAIL_COUNT:   tail_count_q   <= cfg_data_i[TailW-1:0];
        default: ;
      endcase
    end
  end

  // Effective symbol count: zero counts as one, large counts saturate.
  always_comb begin
    s_eff = symbol_count_q;
    if (symbol_count_q == '0) begin
      s_eff = 9'd1;
    end else if ({4'd0, symbol_count_q} > MaxSym) begin
      s_eff = MaxSym[SymW-1:0];
    end
  end

  // Datapath helpers. ratio*41>>12 equals ratio/100 over the whole 10-bit range.
  assign base_prod = 16'(send_ratio_q) * 16'd41;
  assign pct_full  = 11'(send_ratio_q) - 11'(base_q) * 11'd100;
  // v*655>>16 undershoots v/100 by less than one, so one correction follows.
  assign est_prod  = 26'(v_q) * 26'd655;
  assign red_rv    = v_q - 16'(est_q) * 16'd100;
  assign tot_sum   = 14'(red_q) + 14'(sbase_q);
  assign div_shift = {div_rem_q, div_dvd_q[SymW-1]};
  assign div_sub   = div_shift - {2'b00, pace_q};
  assign span_prod = 19'(div_rem_q[SymW-1:0]) * (19'(div_quo_q) + 19'd1);

  // State register; any write restarts the planning pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PL_BASE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      PL_BASE: state_d = PL_REM;
      PL_REM:  state_d = PL_MUL;
      PL_MUL:  state_d = PL_EST;
      PL_EST:  state_d = PL_RED;
      PL_RED:  state_d = PL_TAIL;
      PL_TAIL: state_d = PL_DIV;
      PL_DIV:  state_d = (div_cnt_q == 4'd1) ? PL_SPAN : PL_DIV;
      PL_SPAN: state_d = PL_DONE;
      PL_DONE: state_d = PL_DONE;
      default: state_d = PL_BASE;
    endcase
    if (cfg_we) begin
      state_d = PL_BASE;
    end
  end

  // Planning datapath, one step per state.
  always_ff @(posedge clk_i) begin
    case (state_q)
      PL_BASE: begin
        s_q    <= s_eff;
        base_q <= base_prod[15:12];
      end
      PL_REM: begin
        pct_q <= pct_full[6:0];
      end
      PL_MUL: begin
        v_q     <= 16'(s_q) * 16'(pct_q) + 16'd99;
        sbase_q <= 13'(s_q) * 13'(base_q);
      end
      PL_EST: begin
        est_q <= est_prod[24:16];
      end
      PL_RED: begin
        red_q <= (red_rv >= 16'd100) ? est_q + 9'd1 : est_q;
      end
      PL_TAIL: begin
        if (tail_count_q > red_q) begin
          tail_q    <= red_q;
          pace_q    <= '0;
          clamped_q <= 1'b1;
        end else begin
          tail_q    <= tail_count_q;
          pace_q    <= red_q - tail_count_q;
          clamped_q <= 1'b0;
        end
        total_q   <= (tot_sum > 14'd4095) ? 12'd4095 : tot_sum[TotW-1:0];
        div_rem_q <= '0;
        div_dvd_q <= s_q;
        div_quo_q <= '0;
        div_cnt_q <= 4'(SymW);
      end
      PL_DIV: begin
        // Restoring division of S by pace, one quotient bit a cycle.
        if (div_sub[DsrW] == 1'b0) begin
          div_rem_q <= div_sub[DsrW-1:0];
          div_quo_q <= {div_quo_q[SymW-2:0], 1'b1};
        end else begin
          div_rem_q <= div_shift[DsrW-1:0];
          div_quo_q <= {div_quo_q[SymW-2:0], 1'b0};
        end
        div_dvd_q <= {div_dvd_q[SymW-2:0], 1'b0};
        div_cnt_q <= div_cnt_q - 4'd1;
      end
      PL_SPAN: begin
        q_q        <= div_quo_q;
        big_span_q <= (pace_q == '0) ? '0 : span_prod[SymW-1:0];
      end
      default: ;
    endcase
  end

  // Plan seen by the item pipeline.
  always_comb begin
    plan_o.done     = (state_q == PL_DONE);
    plan_o.s        = s_q;
    plan_o.base     = base_q;
    plan_o.tail     = tail_q;
    plan_o.pace     = pace_q;
    plan_o.q        = q_q;
    plan_o.big_span = big_span_q;
    plan_o.total    = total_q;
    plan_o.clamped  = clamped_q;
  end

  // A write always invalidates the plan on the next cycle.
  a_write_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> !plan_o.done)
    else $error("plan still marked done after a configuration write");

  // The clamped tail and the paced count add back up to the redundant count.
  a_split_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plan_o.done |-> (10'(tail_q) + 10'(pace_q) == 10'(red_q)))
    else $error("tail plus pace differs from redundant count");

  // With pacing active every sub-generation holds at least one symbol.
  a_quotient_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (plan_o.done && pace_q != '0) |-> (q_q != '0))
    else $error("sub-generation size is zero");

  // The larger sub-generations never reach past the generation.
  a_span_in_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plan_o.done |-> (big_span_q <= s_q))
    else $error("large sub-generation span exceeds symbol count");

endmodule

// ===== src/frpp_rem_stage.sv =====
// One register stage of the pipelined remainder unit, a few restoring steps deep.
// Depends on frpp_pkg for the item payload type and step count.
`timescale 1ns / 1ps

module frpp_rem_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  frpp_pkg::rem_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output frpp_pkg::rem_t data_o
);
  import frpp_pkg::*;

  logic valid_q;
  rem_t data_q;
  rem_t data_d;

  // Restoring steps: shift in the next dividend bit, subtract where it fits.
  always_comb begin
    logic [DsrW:0] shifted;
    logic [DsrW:0] diff;
    data_d = data_i;
    for (int k = 0; k < RemSteps; k++) begin
      shifted    = {data_d.rem, data_d.dvd[DvdW-1]};
      diff       = shifted - {1'b0, data_d.dsr};
      data_d.rem = (diff[DsrW] == 1'b0) ? diff[DsrW-1:0] : shifted[DsrW-1:0];
      data_d.dvd = {data_d.dvd[DvdW-2:0], 1'b0};
    end
  end

  assign ready_o = !valid_q || ready_i;

  // Stage register with its valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/fec_redundancy_pacing_planner.sv =====
// Top level of the FEC redundancy pacing planner: plan unit plus item pipeline.
// Depends on frpp_pkg, frpp_plan and frpp_rem_stage.
`timescale 1ns / 1ps

// Usage:
// The configuration channel (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
// writes symbol_count (index 0), the send ratio (1) and tail_count (2); it is
// always ready. After reset and after every write the plan unit derives base,
// redundant, tail and pacing figures, one sequencer step a cycle with a
// bit-serial division of the symbol count by the pace; until the plan is
// done s_axis_tready_o stays low.
// Each input item on s_axis carries a symbol index; each result on m_axis
// carries the packet count for that symbol, the packets per generation and
// the tail clamp flag. One item is accepted per cycle once the plan is ready
// and while the pipeline is not backed up. An item passes five registers: an
// entry stage, three stages of the remainder unit (three restoring steps each)
// and the output register, which drives m_axis_tvalid_o. Each stage has
// its own valid bit; when the receiver stalls, results wait in the output
// register and items keep entering until the stages ahead are full, so
// nothing is lost or repeated.
// Reset clears all valid bits and restores the register defaults.

module fec_redundancy_pacing_planner #(
  parameter int MAX_SYMBOLS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [frpp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [frpp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: symbol_index [7:0]
  input  logic [7:0]                    s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata: packets_for_symbol [8:0], total_packets [20:9], tail_clamped [21], zero [23:22]
  output logic [23:0]                   m_axis_tdata_o
);
  import frpp_pkg::*;

  plan_t plan;

  logic            s0_valid_q;
  logic [IdxW-1:0] s0_idx_q;
  logic            s0_ready;

  logic            st_valid [RemStages+1];
  logic            st_ready [RemStages+1];
  rem_t            st_data  [RemStages+1];

  logic            out_valid_q;
  logic [23:0]     out_data_q;
  logic            out_ready;

  logic [SymW-1:0] idx9;
  logic            in_big;
  rem_t            fin;
  logic [SymW-1:0] fin_idx9;
  logic            extra;
  logic [9:0]      pkt_sum;
  logic [PktW-1:0] pkt_sat;

  frpp_plan #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_plan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .plan_o      (plan)
  );

  // Entry stage: register the symbol index.
  assign s0_ready        = !s0_valid_q || st_ready[0];
  assign s_axis_tready_o = plan.done && s0_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_q <= s_axis_tvalid_i && plan.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      s0_idx_q <= s_axis_tdata_i;
    end
  end

  // Choose dividend and divisor: large sub-generations first, then the rest.
  assign idx9   = {1'b0, s0_idx_q};
  assign in_big = idx9 < plan.big_span;

  always_comb begin
    st_data[0].idx = s0_idx_q;
    st_data[0].rem = '0;
    if (in_big) begin
      st_data[0].dvd = idx9 + 9'd1;
      st_data[0].dsr = {1'b0, plan.q} + 10'd1;
    end else begin
      st_data[0].dvd = idx9 - plan.big_span + 9'd1;
      st_data[0].dsr = {1'b0, plan.q};
    end
  end
  assign st_valid[0] = s0_valid_q;

  // Remainder pipeline.
  for (genvar i = 0; i < RemStages; i++) begin : g_rem
    frpp_rem_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[i]),
      .ready_o (st_ready[i]),
      .data_i  (st_data[i]),
      .valid_o (st_valid[i+1]),
      .ready_i (st_ready[i+1]),
      .data_o  (st_data[i+1])
    );
  end

  // Final count: base, one extra at a sub-generation end, tail on the last symbol.
  assign fin      = st_data[RemStages];
  assign fin_idx9 = {1'b0, fin.idx};
  assign extra    = (plan.pace != '0) && (fin.rem == '0);

  always_comb begin
    pkt_sum = 10'(plan.base) + 10'(extra);
    if (fin_idx9 == plan.s - 9'd1) begin
      pkt_sum = pkt_sum + 10'(plan.tail);
    end
    pkt_sat = pkt_sum[9] ? 9'd511 : pkt_sum[PktW-1:0];
    if (fin_idx9 >= plan.s) begin
      pkt_sat = '0;
    end
  end

  // Output register.
  assign out_ready             = !out_valid_q || m_axis_tready_i;
  assign st_ready[RemStages]   = out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= st_valid[RemStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && st_valid[RemStages]) begin
      out_data_q <= {2'b00, plan.clamped, plan.total, pkt_sat};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for fec_redundancy_pacing_planner.
// Drives symbol indexes and plan settings, predicts every result and checks it.
// Depends on frpp_pkg and the planner RTL only.
`timescale 1ns / 1ps

module tb;
  import frpp_pkg::*;

  localparam int          MAX_SYMBOLS  = 256;
  localparam int unsigned PCT          = 100;
  localparam int unsigned PKT_LIMIT    = 511;
  localparam int unsigned TOTAL_LIMIT  = 4095;
  localparam int unsigned ITEM_TARGET  = 1450;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  // One predicted result item.
  typedef struct packed {
    logic [PktW-1:0] pkts;
    logic [TotW-1:0] total;
    logic            clamped;
  } pkt_plan_t;

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  // tdata: symbol_index [7:0]
  logic [7:0]          s_axis_tdata_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // tdata: packets_for_symbol [8:0], total_packets [20:9], tail_clamped [21]
  logic [23:0]         m_axis_tdata_o;

  // Local copy of the plan registers, reset values included.
  int unsigned cfg_symbols = 16;
  int unsigned cfg_ratio   = 100;
  int unsigned cfg_tail    = 0;

  pkt_plan_t   expected_results[$];
  int unsigned mismatches     = 0;
  int unsigned items_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned plans_applied  = 0;
  int unsigned clamped_seen   = 0;
  int unsigned held_cycles    = 0;
  bit          tx_idle_on     = 1'b0;
  bit          rx_stall_on    = 1'b0;
  bit          rx_hold_req    = 1'b0;

  fec_redundancy_pacing_planner #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Free-running 100 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Symbol count as the block uses it: zero means one, and it saturates.
  function automatic int unsigned used_symbols();
    int unsigned s;
    s = cfg_symbols;
    if (s == 0) s = 1;
    if (s > MAX_SYMBOLS) s = MAX_SYMBOLS;
    return s;
  endfunction

  // Packets after one symbol, packets per generation and the clamp flag.
  function automatic pkt_plan_t predict_packets(input logic [7:0] idx);
    int unsigned s, pos, base, red, tail, pace, q, r, big_span, total, pkts;
    pkt_plan_t   res;
    s    = used_symbols();
    pos  = idx;
    base = cfg_ratio / PCT;
    red  = (s * (cfg_ratio % PCT) + PCT - 1) / PCT;
    tail = cfg_tail;
    res.clamped = 1'b0;
    if (tail > red) begin
      tail = red;
      res.clamped = 1'b1;
    end
    pace  = red - tail;
    total = red + s * base;
    if (total > TOTAL_LIMIT) total = TOTAL_LIMIT;
    pkts = 0;
    if (pos < s) begin
      pkts = base;
      // Larger sub-generations come first; each one ends with an extra packet.
      if (pace > 0) begin
        q        = s / pace;
        r        = s % pace;
        big_span = r * (q + 1);
        if (pos < big_span) begin
          if ((pos + 1) % (q + 1) == 0) pkts++;
        end else if ((pos - big_span + 1) % q == 0) begin
          pkts++;
        end
      end
      if (pos == s - 1) pkts += tail;
      if (pkts > PKT_LIMIT) pkts = PKT_LIMIT;
    end
    res.pkts  = pkts[PktW-1:0];
    res.total = total[TotW-1:0];
    return res;
  endfunction

  // Sender gap length: mostly none or short, now and then long.
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver stall length: mostly short, now and then long.
  function automatic int unsigned stall_length();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Offers one item until it is taken, records the expectation, then maybe idles.
  task automatic send_symbol(input logic [7:0] idx);
    int unsigned gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= idx;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_results.push_back(predict_packets(idx));
    items_sent++;
    gap = tx_idle_on ? idle_length() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops offering items and waits for every outstanding result.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // One register write; the valid stays high for a following write.
  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      CFG_SYMBOL_COUNT: cfg_symbols = value & 10'h1FF;
      CFG_SEND_RATIO:   cfg_ratio   = value;
      CFG_TAIL_COUNT:   cfg_tail    = value & 10'h1FF;
      default: ;
    endcase
  endtask

  // Writes all three plan registers, optionally pokes the unused index too.
  task automatic apply_plan(input logic [CfgDataW-1:0] sym, input logic [CfgDataW-1:0] ratio,
                            input logic [CfgDataW-1:0] tail, input bit poke_unused);
    write_reg(CFG_SYMBOL_COUNT, sym);
    write_reg(CFG_SEND_RATIO, ratio);
    write_reg(CFG_TAIL_COUNT, tail);
    if (poke_unused) write_reg(CFG_UNUSED, CfgDataW'($urandom_range(0, 1023)));
    cfg_valid_i <= 1'b0;
    plans_applied++;
  endtask

  // Receiver: random stalls, or a long hold-off on request.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) begin
          @(posedge clk_i);
          held_cycles++;
        end
        rx_hold_req = 1'b0;
        m_axis_tready_i <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (rx_stall_on && $urandom_range(0, 3) == 0) stall_left = stall_length();
      end
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    pkt_plan_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, actual tdata %h", $time, m_axis_tdata_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (want.clamped) clamped_seen++;
        if (m_axis_tdata_o[8:0] !== want.pkts) begin
          $display("%0t: packets_for_symbol expected %0d, actual %0d",
                   $time, want.pkts, m_axis_tdata_o[8:0]);
          mismatches++;
        end
        if (m_axis_tdata_o[20:9] !== want.total) begin
          $display("%0t: total_packets expected %0d, actual %0d",
                   $time, want.total, m_axis_tdata_o[20:9]);
          mismatches++;
        end
        if (m_axis_tdata_o[21] !== want.clamped) begin
          $display("%0t: tail_clamped expected %0b, actual %0b",
                   $time, want.clamped, m_axis_tdata_o[21]);
          mismatches++;
        end
      end
    end
  end

  // Reset settings: one unit per symbol, nothing redundant, short generation.
  task automatic test_reset_defaults();
    send_symbol(8'd0);
    send_symbol(8'd15);
    send_symbol(8'd16);
    send_symbol(8'd255);
    drain_results();
  endtask

  // Extreme and special settings with a few chosen indexes each.
  task automatic test_corner_settings();
    // Largest legal generation at the highest fractional ratio.
    apply_plan(10'd256, 10'd799, 10'd0, 1'b0);
    send_symbol(8'd0);
    send_symbol(8'd1);
    send_symbol(8'd2);
    send_symbol(8'd254);
    send_symbol(8'd255);
    drain_results();
    // Zero symbol count acts as one; tail above the redundant count is clamped.
    apply_plan(10'd0, 10'd150, 10'd300, 1'b1);
    send_symbol(8'd0);
    send_symbol(8'd1);
    send_symbol(8'd255);
    drain_results();
    // Oversized count saturates; ratio beyond the legal range is used as is.
    apply_plan(10'd511, 10'd1023, 10'd511, 1'b0);
    send_symbol(8'd0);
    send_symbol(8'd255);
    drain_results();
    // Uneven split: first sub-generation one larger, plus a tail.
    apply_plan(10'd10, 10'd350, 10'd2, 1'b1);
    send_symbol(8'd3);
    send_symbol(8'd4);
    send_symbol(8'd9);
    drain_results();
    // A single paced packet across the whole generation.
    apply_plan(10'd7, 10'd101, 10'd0, 1'b0);
    send_symbol(8'd3);
    send_symbol(8'd6);
    drain_results();
    // Ratio below one hundred: no base packets at all.
    apply_plan(10'd5, 10'd50, 10'd0, 1'b0);
    send_symbol(8'd0);
    send_symbol(8'd1);
    send_symbol(8'd4);
    drain_results();
  endtask

  // The receiver holds off long enough for the pipeline to back up to the input.
  task automatic test_stalled_receiver();
    apply_plan(10'd64, 10'd250, 10'd3, 1'b0);
    tx_idle_on  = 1'b0;
    rx_hold_req = 1'b1;
    repeat (60) send_symbol(8'($urandom_range(0, 63)));
    drain_results();
  endtask

  // Random settings per phase, mostly in-generation indexes with some noise.
  task automatic test_random_plans();
    logic [CfgDataW-1:0] sym, ratio, tail;
    int unsigned         phase_len, s, roll;
    while (items_sent < ITEM_TARGET) begin
      sym   = CfgDataW'($urandom_range(1, 256));
      ratio = CfgDataW'($urandom_range(100, 800));
      tail  = CfgDataW'($urandom_range(0, 20));
      case ($urandom_range(0, 9))
        0: sym   = CfgDataW'($urandom_range(0, 1023));
        1: ratio = CfgDataW'($urandom_range(0, 1023));
        2: tail  = CfgDataW'($urandom_range(0, 511));
        3: sym   = CfgDataW'($urandom_range(1, 8));
        4: ratio = CfgDataW'(100 * $urandom_range(1, 8));
        5: sym   = CfgDataW'($urandom_range(200, 256));
        default: ;
      endcase
      apply_plan(sym, ratio, tail, $urandom_range(0, 7) == 0);
      tx_idle_on  = $urandom_range(0, 2) != 0;
      rx_stall_on = $urandom_range(0, 2) != 0;
      s = used_symbols();
      phase_len = $urandom_range(30, 120);
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 70)      send_symbol(8'($urandom_range(0, s - 1)));
        else if (roll < 80) send_symbol(8'(s - 1));
        else if (roll < 88) send_symbol(8'd0);
        else                send_symbol(8'($urandom_range(0, 255)));
      end
      drain_results();
    end
    rx_stall_on = 1'b0;
  endtask

  // Test sequence and final verdict.
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_corner_settings();
    test_stalled_receiver();
    test_random_plans();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      mismatches++;
    end
    $display("tb: %0d symbols planned under %0d register settings, %0d results checked",
             items_sent, plans_applied, results_seen);
    $display("tb: %0d clamped tails seen, receiver held off %0d cycles, %0d mismatches",
             clamped_seen, held_cycles, mismatches);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10ms;
    $display("tb: timeout");
    $display("tb: done, errors");
    $finish;
  end

endmodule
